FILE: rtl/core/rsos_pkg.sv
// ----------------------------------------------------------------------------
// rsos_pkg: shared types and constants of the range scan object segmenter
// Holds the fixed field widths, the register index codes, the status struct
// of the serial units and the half-angle sine table in Q1.16.
// ----------------------------------------------------------------------------
package rsos_pkg;

	// Fixed field widths
	localparam int ANGLE_W   = 8;
	localparam int FIELD_W   = 16;
	localparam int TOTAL_W   = 32;
	localparam int COUNT_W   = 16;
	localparam int SINE_W    = 17;
	localparam int PRODUCT_W = TOTAL_W + SINE_W;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_LIMIT   = 2'd2;

	// Register reset values
	localparam logic [FIELD_W-1:0] EDGE_THRESHOLD_RST = 16'd26;
	localparam logic [ANGLE_W-1:0] MIN_WIDTH_RST      = 8'd4;
	localparam logic [ANGLE_W-1:0] OBJECT_LIMIT_RST   = 8'd10;

	// Status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Half-angle sine table, index is the span folded into 0..180 degrees
	localparam int SINE_MAX_K = 180;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] TERM_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272};

	typedef logic [SINE_W-1:0] sine_table_t [0:SINE_MAX_K];

	// Taylor series of sin in Q2.30, rounded to Q1.16; evaluated at elaboration
	function automatic sine_table_t build_sine_table();
		sine_table_t tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		int k;
		int n;
		for (k = 0; k <= SINE_MAX_K; k++) begin
			x    = (64'(k) * PI_Q30) / 64'd360;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / TERM_DIV[n];
				if (n[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			rnd    = (sum + 64'd8192) >> 14;
			tab[k] = rnd[SINE_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

FILE: rtl/core/rsos_divider.sv
// ----------------------------------------------------------------------------
// rsos_divider: bit-serial restoring divider
// Divides the 32-bit distance total by the 16-bit sample count, one quotient
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module rsos_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rsos_pkg::TOTAL_W-1:0]   dividend,
	input  logic [rsos_pkg::COUNT_W-1:0]   divisor,
	output logic [rsos_pkg::TOTAL_W-1:0]   quotient,
	output rsos_pkg::unit_stat_t           stat
);
	import rsos_pkg::*;

	localparam int CNT_W = $clog2(TOTAL_W);

	logic [COUNT_W-1:0] rem_q;
	logic [TOTAL_W-1:0] quo_q;
	logic [COUNT_W-1:0] dsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COUNT_W:0]   shifted;
	logic [COUNT_W:0]   trial;
	logic               fits;

	// Bring down the next dividend bit and try the subtract
	assign shifted = {rem_q, quo_q[TOTAL_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TOTAL_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
			quo_q <= {quo_q[TOTAL_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/core/rsos_multiplier.sv
// ----------------------------------------------------------------------------
// rsos_multiplier: bit-serial shift-add multiplier
// Multiplies the mean distance by the half-angle sine, one multiplier bit
// per cycle, least significant bit first.
// ----------------------------------------------------------------------------
module rsos_multiplier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rsos_pkg::TOTAL_W-1:0]   mcand,
	input  logic [rsos_pkg::SINE_W-1:0]    mplier,
	output logic [rsos_pkg::PRODUCT_W-1:0] product,
	output rsos_pkg::unit_stat_t           stat
);
	import rsos_pkg::*;

	localparam int CNT_W = $clog2(SINE_W);

	logic [TOTAL_W-1:0] hi_q;
	logic [SINE_W-1:0]  lo_q;
	logic [TOTAL_W-1:0] mcand_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [TOTAL_W:0]   partial;

	// Add the multiplicand when the current multiplier bit is set
	assign partial = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SINE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: shift the partial product right one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q    <= '0;
			lo_q    <= mplier;
			mcand_q <= mcand;
		end else if (busy_q) begin
			hi_q <= partial[TOTAL_W:1];
			lo_q <= {partial[0], lo_q[SINE_W-1:1]};
		end
	end

	assign product   = {hi_q, lo_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/core/range_scan_object_segmenter.sv
// A sample that closes an accepted object gives its record after the serial divider,
// then the serial multiplier and the finish state load it into the output register.
// Throughput: one sample per cycle while no object is being finished; a finishing
// sample holds the input until the record is loaded into the output register.
// Reset: arst_n clears history, object tracking, counters and narrowest record at once;
// the registers return to threshold 26, minimum width 4, object limit 10.
// ----------------------------------------------------------------------------
// range_scan_object_segmenter: edge-based object segmentation of range scans
// Tracks falling and rising distance edges over a scan, accumulates the
// samples on each object and reports its angles, mean distance, chord width
// and the narrowest object seen so far.
// ----------------------------------------------------------------------------
module range_scan_object_segmenter #(
	parameter int DISTANCE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// sample input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] range_sample,
	input  logic [7:0]  scan_angle,
	// object record output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  object_number,
	output logic [7:0]  first_angle,
	output logic [7:0]  last_angle,
	output logic [7:0]  middle_angle,
	output logic [7:0]  angular_span,
	output logic [15:0] mean_distance,
	output logic [15:0] chord_width,
	output logic [7:0]  narrowest_number,
	output logic [15:0] narrowest_width
);
	import rsos_pkg::*;

	localparam int DB            = DISTANCE_BITS;
	localparam int CW            = (DB > FIELD_W) ? DB : FIELD_W;
	localparam int CHORD_FULL_W  = PRODUCT_W + 1 - 15;
	localparam logic [CHORD_FULL_W-1:0] CHORD_MAX =
		CHORD_FULL_W'((64'd1 << DISTANCE_BITS) - 64'd1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// Configuration registers
	logic [FIELD_W-1:0] edge_threshold_q;
	logic [ANGLE_W-1:0] min_width_q;
	logic [ANGLE_W-1:0] object_limit_q;

	// Scan tracking state
	logic               history_valid_q;
	logic               inside_object_q;
	logic [DB-1:0]      prev_distance_q;
	logic [ANGLE_W-1:0] prev_angle_q;
	logic [ANGLE_W-1:0] leading_angle_q;
	logic [TOTAL_W-1:0] distance_total_q;
	logic [COUNT_W-1:0] sample_count_q;
	logic [ANGLE_W-1:0] recorded_count_q;
	logic [FIELD_W-1:0] best_width_q;
	logic [ANGLE_W-1:0] best_number_q;

	// Object being finished
	logic [1:0]         state_q;
	logic [ANGLE_W-1:0] job_first_q;
	logic [ANGLE_W-1:0] job_last_q;
	logic [ANGLE_W-1:0] job_span_q;
	logic [SINE_W-1:0]  job_sine_q;
	logic [ANGLE_W-1:0] job_number_q;

	// Output register
	logic               out_valid_q;
	logic [ANGLE_W-1:0] object_number_q;
	logic [ANGLE_W-1:0] first_angle_q;
	logic [ANGLE_W-1:0] last_angle_q;
	logic [ANGLE_W-1:0] middle_angle_q;
	logic [ANGLE_W-1:0] angular_span_q;
	logic [FIELD_W-1:0] mean_distance_q;
	logic [FIELD_W-1:0] chord_width_q;
	logic [ANGLE_W-1:0] narrowest_number_q;
	logic [FIELD_W-1:0] narrowest_width_q;

	// Accept-cycle signals
	logic               accept;
	logic [DB-1:0]      cur;
	logic [DB-1:0]      fall_diff;
	logic [DB-1:0]      rise_diff;
	logic               is_fall;
	logic               is_rise;
	logic [ANGLE_W-1:0] obj_span;
	logic               qualifies;
	logic [TOTAL_W:0]   total_sum;
	logic [ANGLE_W:0]   folded_k;
	logic               emit;

	logic               nx_inside;
	logic [ANGLE_W-1:0] nx_leading;
	logic [TOTAL_W-1:0] nx_total;
	logic [COUNT_W-1:0] nx_count;

	// Finish-stage signals
	logic [TOTAL_W-1:0]      quotient;
	logic [PRODUCT_W-1:0]    product;
	unit_stat_t              div_stat;
	unit_stat_t              mul_stat;
	logic [PRODUCT_W:0]      rounded;
	logic [CHORD_FULL_W-1:0] chord_full;
	logic [DB-1:0]           chord_sat;
	logic [CW-1:0]           chord_ext;
	logic                    new_best;
	logic                    load_out;
	logic [ANGLE_W:0]        angle_sum;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cur       = DB'(range_sample);

	// Edge tests without wrap
	assign fall_diff = prev_distance_q - cur;
	assign rise_diff = cur - prev_distance_q;
	assign is_fall   = (cur < prev_distance_q) && (CW'(fall_diff) > CW'(edge_threshold_q));
	assign is_rise   = (cur > prev_distance_q) && (CW'(rise_diff) > CW'(edge_threshold_q));

	// Object acceptance test at the trailing edge
	assign obj_span  = prev_angle_q - leading_angle_q;
	assign qualifies = (prev_angle_q >= leading_angle_q) && (obj_span >= min_width_q) &&
		(recorded_count_q < object_limit_q);

	// Saturating accumulation
	assign total_sum = {1'b0, distance_total_q} + (TOTAL_W + 1)'(cur);

	// Fold spans above 180 degrees back onto the table
	assign folded_k = (obj_span <= ANGLE_W'(SINE_MAX_K)) ? {1'b0, obj_span} :
		(ANGLE_W + 1)'(2 * SINE_MAX_K) - {1'b0, obj_span};

	// Next tracking state for an accepted sample
	always_comb begin
		nx_inside  = inside_object_q;
		nx_leading = leading_angle_q;
		nx_total   = distance_total_q;
		nx_count   = sample_count_q;
		emit       = 1'b0;
		if (history_valid_q) begin
			if (!inside_object_q) begin
				if (is_fall) begin
					nx_inside  = 1'b1;
					nx_leading = scan_angle;
					nx_total   = TOTAL_W'(cur);
					nx_count   = COUNT_W'(1);
				end
			end else if (is_rise) begin
				nx_inside = 1'b0;
				emit      = qualifies;
			end else begin
				nx_total = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
				if (sample_count_q != '1) begin
					nx_count = sample_count_q + 1'b1;
				end
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_threshold_q <= EDGE_THRESHOLD_RST;
			min_width_q      <= MIN_WIDTH_RST;
			object_limit_q   <= OBJECT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EDGE_THRESHOLD: begin
					edge_threshold_q <= cfg_data;
				end
				CFG_MIN_WIDTH: begin
					min_width_q <= cfg_data[ANGLE_W-1:0];
				end
				CFG_OBJECT_LIMIT: begin
					object_limit_q <= cfg_data[ANGLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Advance scan tracking on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_valid_q  <= 1'b0;
			inside_object_q  <= 1'b0;
			prev_distance_q  <= '0;
			prev_angle_q     <= '0;
			leading_angle_q  <= '0;
			distance_total_q <= '0;
			sample_count_q   <= '0;
			recorded_count_q <= '0;
		end else if (accept) begin
			history_valid_q  <= 1'b1;
			inside_object_q  <= nx_inside;
			prev_distance_q  <= cur;
			prev_angle_q     <= scan_angle;
			leading_angle_q  <= nx_leading;
			distance_total_q <= nx_total;
			sample_count_q   <= nx_count;
			if (emit) begin
				recorded_count_q <= recorded_count_q + 1'b1;
			end
		end
	end

	// Capture the object being finished
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			job_first_q  <= leading_angle_q;
			job_last_q   <= prev_angle_q;
			job_span_q   <= obj_span;
			job_sine_q   <= SINE_TABLE[folded_k[ANGLE_W-1:0]];
			job_number_q <= recorded_count_q + 1'b1;
		end
	end

	// Mean distance, one quotient bit per cycle
	rsos_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && emit),
		.dividend (distance_total_q),
		.divisor  (sample_count_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Mean times half-angle sine, one multiplier bit per cycle
	rsos_multiplier u_multiplier (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_stat.done),
		.mcand   (quotient),
		.mplier  (job_sine_q),
		.product (product),
		.stat    (mul_stat)
	);

	// Chord = (2 * mean * S + 2^15) >> 16, saturated
	assign rounded    = {1'b0, product} + (PRODUCT_W + 1)'(16384);
	assign chord_full = rounded[PRODUCT_W:15];
	assign chord_sat  = DB'((chord_full > CHORD_MAX) ? CHORD_MAX : chord_full);
	assign chord_ext  = CW'(chord_sat);
	assign new_best   = (best_number_q == '0) || (chord_ext < CW'(best_width_q));
	assign load_out   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign angle_sum  = {1'b0, job_first_q} + {1'b0, job_last_q};

	// Sequence the finishing of one object
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && emit) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Narrowest object so far, first one wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_width_q  <= '1;
			best_number_q <= '0;
		end else if (load_out && new_best) begin
			best_width_q  <= chord_ext[FIELD_W-1:0];
			best_number_q <= job_number_q;
		end
	end

	// Output beat valid: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			object_number_q    <= job_number_q;
			first_angle_q      <= job_first_q;
			last_angle_q       <= job_last_q;
			middle_angle_q     <= angle_sum[ANGLE_W:1];
			angular_span_q     <= job_span_q;
			mean_distance_q    <= quotient[FIELD_W-1:0];
			chord_width_q      <= chord_ext[FIELD_W-1:0];
			narrowest_number_q <= new_best ? job_number_q : best_number_q;
			narrowest_width_q  <= new_best ? chord_ext[FIELD_W-1:0] : best_width_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign object_number    = object_number_q;
	assign first_angle      = first_angle_q;
	assign last_angle       = last_angle_q;
	assign middle_angle     = middle_angle_q;
	assign angular_span     = angular_span_q;
	assign mean_distance    = mean_distance_q;
	assign chord_width      = chord_width_q;
	assign narrowest_number = narrowest_number_q;
	assign narrowest_width  = narrowest_width_q;

`ifndef SYNTH
	// No sample is taken while a serial unit still works on an object
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(div_stat.busy || mul_stat.busy))
		else $error("sample accepted while divider or multiplier busy");

	// The multiplier finishes only while the sequencer waits for it
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_MUL))
		else $error("multiplier done outside multiply phase");

	// The narrowest record always names an object already recorded
	a_best_number: assert property (@(posedge clk) disable iff (!arst_n)
		best_number_q <= recorded_count_q)
		else $error("narrowest object number beyond recorded count");

	// A record loaded into the output register is presented next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid && (object_number == $past(job_number_q))))
		else $error("finished object not presented at output");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for range_scan_object_segmenter
// Streams range samples through the block under random input gaps and output
// stalls. An in-bench segmentation model predicts every object record, and the
// monitor checks each record against it in order. The bench covers edge
// thresholds, span and limit rejects, wide and reversed angles, narrowest
// ties and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
	import rsos_pkg::*;

	localparam int          SETTLE_CYCLES = 80;
	localparam int          HOLD_CYCLES   = 600;
	localparam int          RANDOM_ITEMS  = 560;
	localparam int          TIMEOUT_NS    = 6000000;
	localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic [FIELD_W-1:0] distance;
		logic [ANGLE_W-1:0] angle;
	} scan_item_t;

	typedef struct packed {
		logic [7:0]  object_number;
		logic [7:0]  first_angle;
		logic [7:0]  last_angle;
		logic [7:0]  middle_angle;
		logic [7:0]  angular_span;
		logic [15:0] mean_distance;
		logic [15:0] chord_width;
		logic [7:0]  narrowest_number;
		logic [15:0] narrowest_width;
	} obj_rec_t;

	// DUT ports
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [15:0]          cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [15:0]          range_sample = '0;
	logic [7:0]           scan_angle   = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [7:0]           object_number;
	logic [7:0]           first_angle;
	logic [7:0]           last_angle;
	logic [7:0]           middle_angle;
	logic [7:0]           angular_span;
	logic [15:0]          mean_distance;
	logic [15:0]          chord_width;
	logic [7:0]           narrowest_number;
	logic [15:0]          narrowest_width;

	// Segmentation model: configuration and tracking state
	logic [15:0] edge_thr  = EDGE_THRESHOLD_RST;
	logic [7:0]  min_span  = MIN_WIDTH_RST;
	logic [7:0]  obj_limit = OBJECT_LIMIT_RST;
	logic        primed    = 1'b0;
	logic        in_obj    = 1'b0;
	logic [15:0] prev_range = '0;
	logic [7:0]  prev_ang  = '0;
	logic [7:0]  lead_ang  = '0;
	logic [31:0] range_sum = '0;
	logic [15:0] hit_count = '0;
	logic [7:0]  obj_count = '0;
	logic [15:0] min_chord = '1;
	logic [7:0]  min_id    = '0;

	// Bench bookkeeping
	scan_item_t  sample_q[$];
	obj_rec_t    record_q[$];
	int unsigned samples_offered = 0;
	int unsigned samples_taken   = 0;
	int unsigned queued_total    = 0;
	int unsigned records_seen    = 0;
	int unsigned cfg_writes      = 0;
	int unsigned fail_count      = 0;
	int unsigned burst_left      = 1;
	int unsigned gap_left        = 0;
	logic        rx_blocked      = 1'b0;
	rx_mode_t    rx_mode         = RX_STEADY;
	int unsigned rx_mode_left    = 0;
	logic [1:0]  rx_tick         = '0;

	range_scan_object_segmenter u_top (.*);

	always #1 clk = ~clk;

	// sin(span/2) in Q1.16 from a Q2.30 Taylor series, rounded to nearest
	function automatic logic [16:0] half_angle_sine(input logic [7:0] span);
		logic [63:0] k;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		int          n;
		k    = (span <= 8'd180) ? 64'(span) : 64'd360 - 64'(span);
		x    = (k * HALF_TURN_Q30) / 64'd360;
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		for (n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		return 17'((acc + 64'd8192) >> 14);
	endfunction

	// Advance the model by one sample; returns 1 when an object is recorded
	function automatic bit segment_sample(input logic [15:0] range_in,
			input logic [7:0] angle_in, output obj_rec_t rec);
		logic [32:0] wide_sum;
		logic [7:0]  span;
		logic [31:0] avg;
		logic [63:0] chord;
		bit          emit;
		emit = 1'b0;
		rec  = '0;
		if (!primed) begin
			primed     = 1'b1;
			prev_range = range_in;
			prev_ang   = angle_in;
			return 1'b0;
		end
		if (!in_obj) begin
			// falling edge opens an object seeded with this sample
			if (range_in < prev_range && prev_range - range_in > edge_thr) begin
				in_obj    = 1'b1;
				lead_ang  = angle_in;
				range_sum = 32'(range_in);
				hit_count = 16'd1;
			end
		end else if (range_in > prev_range && range_in - prev_range > edge_thr) begin
			// rising edge closes the object at the previous angle
			in_obj = 1'b0;
			if (prev_ang >= lead_ang && prev_ang - lead_ang >= min_span &&
					obj_count < obj_limit) begin
				span  = prev_ang - lead_ang;
				avg   = (hit_count != 0) ? range_sum / 32'(hit_count) : 32'd0;
				chord = (64'(avg) * 64'd2 * 64'(half_angle_sine(span)) + 64'd32768) >> 16;
				if (chord > 64'hFFFF) begin
					chord = 64'hFFFF;
				end
				obj_count = obj_count + 8'd1;
				// strict compare keeps the earlier object on a tie
				if (min_id == 0 || chord[15:0] < min_chord) begin
					min_chord = chord[15:0];
					min_id    = obj_count;
				end
				rec.object_number    = obj_count;
				rec.first_angle      = lead_ang;
				rec.last_angle       = prev_ang;
				rec.middle_angle     = 8'(({1'b0, lead_ang} + {1'b0, prev_ang}) >> 1);
				rec.angular_span     = span;
				rec.mean_distance    = avg[15:0];
				rec.chord_width      = chord[15:0];
				rec.narrowest_number = min_id;
				rec.narrowest_width  = min_chord;
				emit = 1'b1;
			end
		end else begin
			// accumulate with saturation of sum and count
			wide_sum  = {1'b0, range_sum} + 33'(range_in);
			range_sum = wide_sum[32] ? 32'hFFFF_FFFF : wide_sum[31:0];
			if (hit_count != 16'hFFFF) begin
				hit_count = hit_count + 16'd1;
			end
		end
		prev_range = range_in;
		prev_ang   = angle_in;
		return emit;
	endfunction

	function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
		return (a < b) ? a : b;
	endfunction

	function automatic string record_text(input obj_rec_t r);
		return $sformatf("#%0d ang %0d..%0d mid %0d span %0d mean %0d chord %0d best #%0d/%0d",
			r.object_number, r.first_angle, r.last_angle, r.middle_angle, r.angular_span,
			r.mean_distance, r.chord_width, r.narrowest_number, r.narrowest_width);
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("MISMATCH: %s", msg);
		end
	endtask

	task automatic push_sample(input int unsigned level, input int unsigned angle);
		sample_q.push_back('{16'(level), 8'(angle)});
		queued_total++;
	endtask

	// Queue one sweep: background, object plateau, background, with stray noise
	task automatic queue_scan(input int unsigned objects, input bit wide);
		int unsigned thr;
		int unsigned step_max;
		int unsigned ang;
		int unsigned obj;
		int unsigned bg;
		int unsigned margin;
		int unsigned k;
		int unsigned j;
		int unsigned n;
		thr      = edge_thr;
		step_max = wide ? 40 : 3;
		ang      = $urandom_range(40);
		obj      = 0;
		bg       = 65535;
		for (k = 0; k < objects; k++) begin
			if (thr < 65535) begin
				obj    = $urandom_range(65534 - thr);
				margin = lesser(65535 - obj - thr - 1, 4000);
				bg     = obj + thr + 1 + $urandom_range(margin);
			end
			n = $urandom_range(3, 1);
			for (j = 0; j < n; j++) begin
				push_sample(bg + $urandom_range(lesser(thr / 2, 65535 - bg)), ang);
				ang += $urandom_range(step_max);
			end
			n = $urandom_range(8, 1);
			for (j = 0; j < n; j++) begin
				push_sample(obj - $urandom_range(lesser(thr / 2, obj)), ang);
				ang += $urandom_range(step_max);
			end
			if ($urandom_range(9) == 0) begin
				n = $urandom_range(3, 1);
				for (j = 0; j < n; j++) begin
					push_sample($urandom_range(65535), $urandom_range(255));
				end
			end
		end
		push_sample(bg, ang);
	endtask

	// Wait for the input queue and all predicted records to clear
	task automatic drain_results();
		while (sample_q.size() != 0 || in_valid || record_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			CFG_EDGE_THRESHOLD: edge_thr  = value;
			CFG_MIN_WIDTH:      min_span  = value[7:0];
			CFG_OBJECT_LIMIT:   obj_limit = value[7:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drive sample beats in bursts with random gaps
	always @(negedge clk) begin : sample_driver
		if (samples_taken == samples_offered) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (sample_q.size() != 0) begin
				in_valid        <= 1'b1;
				range_sample    <= sample_q[0].distance;
				scan_angle      <= sample_q[0].angle;
				samples_offered <= samples_offered + 1;
				void'(sample_q.pop_front());
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(40, 1);
					gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive out_ready from a changing stall pattern
	always @(negedge clk) begin : record_receiver
		if (rx_mode_left == 0) begin
			rx_mode      <= rx_mode_t'($urandom_range(2));
			rx_mode_left <= $urandom_range(64, 1);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		rx_tick <= rx_tick + 2'd1;
		if (rx_blocked) begin
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_STEADY: out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(1));
				default:   out_ready <= (rx_tick == 2'b11);
			endcase
		end
	end

	// Predict on every accepted sample beat, check every record beat
	always @(posedge clk) begin : record_monitor
		obj_rec_t predicted;
		obj_rec_t seen;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				samples_taken <= samples_taken + 1;
				if (segment_sample(range_sample, scan_angle, predicted)) begin
					record_q.push_back(predicted);
				end
			end
			if (out_valid && out_ready) begin
				seen = {object_number, first_angle, last_angle, middle_angle, angular_span,
					mean_distance, chord_width, narrowest_number, narrowest_width};
				records_seen++;
				if (record_q.size() == 0) begin
					log_failure($sformatf("unexpected record %s", record_text(seen)));
				end else begin
					predicted = record_q.pop_front();
					if (seen !== predicted) begin
						log_failure($sformatf("expected %s, got %s",
							record_text(predicted), record_text(seen)));
					end
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned random_base;
		int unsigned j;
		bit          wide;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sweep under reset settings: threshold 26, span 4, limit 10
		push_sample(1000, 0);     // primes history only
		push_sample(974, 1);      // drop equal to threshold, no edge
		push_sample(947, 2);      // drop above threshold opens object
		push_sample(950, 3);
		push_sample(960, 6);
		push_sample(987, 7);      // closes at angle 6, span exactly the minimum
		push_sample(900, 8);      // next sample after trailing edge opens again
		push_sample(901, 10);
		push_sample(2000, 11);    // span 2, too narrow
		push_sample(0, 20);       // zero distance object
		push_sample(0, 200);
		push_sample(65535, 201);  // full-scale rise, span 180, chord zero
		push_sample(100, 0);
		push_sample(120, 255);
		push_sample(65535, 10);   // span 255 folds the sine argument
		push_sample(30000, 100);
		push_sample(30000, 50);
		push_sample(40000, 60);   // last angle below first, rejected
		push_sample(0, 30);
		push_sample(0, 34);
		push_sample(5000, 35);    // chord ties the narrowest, first one keeps it
		drain_results();

		// Low extremes: every edge counts but the limit blocks all records
		write_register(CFG_EDGE_THRESHOLD, 16'd0);
		write_register(CFG_MIN_WIDTH, 16'd0);
		write_register(CFG_OBJECT_LIMIT, 16'd0);
		write_register(CFG_SPARE, 16'($urandom_range(65535)));
		queue_scan(6, 1'b0);
		for (j = 0; j < 20; j++) begin
			push_sample($urandom_range(65535), $urandom_range(255));
		end
		drain_results();

		// High extremes: no step can exceed a full-scale threshold
		write_register(CFG_EDGE_THRESHOLD, 16'hFFFF);
		write_register(CFG_MIN_WIDTH, 16'd180);
		write_register(CFG_OBJECT_LIMIT, 16'd255);
		for (j = 0; j < 30; j++) begin
			push_sample($urandom_range(65535), $urandom_range(255));
		end
		drain_results();

		// Hold the receiver off while the sender keeps offering beats
		write_register(CFG_EDGE_THRESHOLD, 16'd100);
		write_register(CFG_MIN_WIDTH, 16'd0);
		rx_blocked = 1'b1;
		queue_scan(10, 1'b0);
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_blocked = 1'b0;
		drain_results();

		// Random sweeps, each under its own settings, drained before the next
		random_base = queued_total;
		while (queued_total - random_base < RANDOM_ITEMS) begin
			case ($urandom_range(5))
				0:       write_register(CFG_EDGE_THRESHOLD, 16'd0);
				1:       write_register(CFG_EDGE_THRESHOLD, 16'($urandom_range(30000)));
				default: write_register(CFG_EDGE_THRESHOLD, 16'($urandom_range(3000, 1)));
			endcase
			case ($urandom_range(5))
				0:       write_register(CFG_MIN_WIDTH, {8'($urandom_range(255)), 8'd180});
				1:       write_register(CFG_MIN_WIDTH, 16'($urandom_range(180)));
				default: write_register(CFG_MIN_WIDTH, 16'($urandom_range(8)));
			endcase
			if ($urandom_range(7) == 0) begin
				write_register(CFG_OBJECT_LIMIT, 16'($urandom_range(65535)));
			end else begin
				write_register(CFG_OBJECT_LIMIT, {8'($urandom_range(255)), 8'd255});
			end
			wide = (min_span > 8'd20) || ($urandom_range(5) == 0);
			queue_scan($urandom_range(12, 3), wide);
			drain_results();
		end

		if (record_q.size() != 0) begin
			log_failure($sformatf("%0d records never arrived", record_q.size()));
		end
		$display("Covered %0d samples, %0d object records, %0d register writes.",
			samples_taken, records_seen, cfg_writes);
		$display("Included limit and span rejects, reversed and wide spans, ties and a long stall.");
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d failures", fail_count);
			$display("tb: failure");
		end
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
